// ----- rtl/core/ole_pkg.sv -----
package ole_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_AFTER = 3'd1,
        OP_APPEND    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_KEY   = 3'd4,
        OP_DEL_BACK  = 3'd5,
        OP_FIND      = 3'd6,
        OP_SUM       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EDIT = 3'b100
    } state_t;

    // what every cell of the chain does this cycle
    typedef struct packed {
        logic rotate;
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/ole_cell.sv -----
module ole_cell #(
    parameter int INDEX = 0,
    parameter int POS_W = 4
) (
    input  logic                clk,
    input  ole_pkg::cell_ctrl_t ctrl,
    input  logic [POS_W-1:0]    edit_pos,
    input  logic signed [31:0]  left_value,
    input  logic signed [31:0]  right_value,
    input  logic signed [31:0]  load_value,
    output logic signed [31:0]  value
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.rotate)
        begin
            value_next = right_value;
        end
        else if (ctrl.insert)
        begin
            if (MY_POS == edit_pos)
            begin
                value_next = load_value;
            end
            else if (MY_POS > edit_pos)
            begin
                value_next = left_value;
            end
        end
        else if (ctrl.remove)
        begin
            if (MY_POS >= edit_pos)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/core/ole_scan.sv -----
module ole_scan #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                step_en,
    input  logic [$clog2(CAPACITY)-1:0]         step,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    input  logic signed [31:0]                  key,
    input  logic signed [31:0]                  head_value,
    output logic                                found,
    output logic [$clog2(CAPACITY)-1:0]         match_pos,
    output logic signed [31:0]                  total
);

    localparam int POS_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);

    logic                   found_reg;
    logic                   found_next;
    logic [POS_W-1:0]       match_pos_reg;
    logic [POS_W-1:0]       match_pos_next;
    logic signed [31:0]     total_reg;
    logic signed [31:0]     total_next;
    logic                   in_range;

    // head cell holds entry number step while the ring turns
    assign in_range = CNT_W'(step) < count;

    always_comb
    begin
        found_next     = found_reg;
        match_pos_next = match_pos_reg;
        total_next     = total_reg;
        if (start)
        begin
            found_next     = 1'b0;
            match_pos_next = '0;
            total_next     = '0;
        end
        else if (step_en && in_range)
        begin
            total_next = total_reg + head_value;
            if (!found_reg && (head_value == key))
            begin
                found_next     = 1'b1;
                match_pos_next = step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_pos_reg <= match_pos_next;
        total_reg     <= total_next;
    end

    assign found     = found_reg;
    assign match_pos = match_pos_reg;
    assign total     = total_reg;

endmodule

// ----- rtl/core/ordered_list_engine_unit.sv -----
// channel | signals                                   | accepted when
// --------+-------------------------------------------+-------------------------
// in      | in_valid, in_ready, operation, key, value | in_valid && in_ready
// out     | out_valid, out_ready, status, position,   | out_valid && out_ready
//         | total, occupancy                          |
//
// find, insert-after, delete-key and sum turn the ring of cells once past the
// head comparator/adder before the edit step; other operations go straight to it.
// one item at a time; a finished result sits in the output register while the
// next item is taken, and the edit step waits if that register is still full.
// reset clears the entry count; entry cells hold no reset value.
module ordered_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [3:0]         position,
    output logic signed [31:0] total,
    output logic [4:0]         occupancy
);

    localparam int POS_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam logic [POS_W-1:0] LAST_STEP = POS_W'(CAPACITY-1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    ole_pkg::state_t        state_reg;
    ole_pkg::state_t        state_next;
    ole_pkg::op_t           op_reg;
    ole_pkg::op_t           op_in;
    logic signed [31:0]     key_reg;
    logic signed [31:0]     value_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [POS_W-1:0]       step_reg;
    logic [POS_W-1:0]       step_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    ole_pkg::status_t       status_reg;
    logic [3:0]             position_reg;
    logic signed [31:0]     total_reg;
    logic [4:0]             occupancy_reg;

    logic                   accept;
    logic                   out_free;
    logic                   edit_fire;
    logic                   needs_scan;
    logic                   list_empty;
    logic                   list_full;

    logic                   scan_found;
    logic [POS_W-1:0]       scan_pos;
    logic signed [31:0]     scan_total;

    ole_pkg::cell_ctrl_t    cell_ctrl;
    ole_pkg::cell_ctrl_t    edit_ctrl;
    logic [POS_W-1:0]       edit_pos;
    ole_pkg::status_t       status_c;
    logic [3:0]             position_c;
    logic signed [31:0]     total_c;
    logic [CNT_W-1:0]       count_c;

    logic signed [31:0]     cell_value [CAPACITY];

    assign in_ready   = (state_reg == ole_pkg::S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign edit_fire  = (state_reg == ole_pkg::S_EDIT) && out_free;
    assign op_in      = ole_pkg::op_t'(operation);
    assign needs_scan = op_in inside {ole_pkg::OP_INS_AFTER, ole_pkg::OP_DEL_KEY,
                                      ole_pkg::OP_FIND, ole_pkg::OP_SUM};
    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg >= FULL_COUNT);

    // control
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ole_pkg::S_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    state_next = needs_scan ? ole_pkg::S_SCAN : ole_pkg::S_EDIT;
                end
            end
            ole_pkg::S_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ole_pkg::S_EDIT;
                end
            end
            ole_pkg::S_EDIT:
            begin
                if (out_free)
                begin
                    state_next = ole_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase
    end

    // decide the edit and the result once the scan is over
    always_comb
    begin
        status_c   = ole_pkg::STAT_OK;
        position_c = '0;
        total_c    = '0;
        count_c    = count_reg;
        edit_ctrl  = '0;
        edit_pos   = '0;
        case (op_reg)
            ole_pkg::OP_INS_FRONT:
            begin
                if (list_full)
                begin
                    status_c = ole_pkg::STAT_FULL;
                end
                else
                begin
                    edit_ctrl.insert = 1'b1;
                    count_c = count_reg + 1'b1;
                end
            end
            ole_pkg::OP_INS_AFTER:
            begin
                if (list_empty)
                begin
                    status_c = ole_pkg::STAT_EMPTY;
                end
                else if (list_full)
                begin
                    status_c = ole_pkg::STAT_FULL;
                end
                else if (!scan_found)
                begin
                    status_c = ole_pkg::STAT_MISSING;
                end
                else
                begin
                    edit_ctrl.insert = 1'b1;
                    edit_pos = scan_pos + 1'b1;
                    count_c = count_reg + 1'b1;
                end
            end
            ole_pkg::OP_APPEND:
            begin
                if (list_full)
                begin
                    status_c = ole_pkg::STAT_FULL;
                end
                else
                begin
                    edit_ctrl.insert = 1'b1;
                    edit_pos = POS_W'(count_reg);
                    count_c = count_reg + 1'b1;
                end
            end
            ole_pkg::OP_DEL_FRONT:
            begin
                if (list_empty)
                begin
                    status_c = ole_pkg::STAT_EMPTY;
                end
                else
                begin
                    edit_ctrl.remove = 1'b1;
                    count_c = count_reg - 1'b1;
                end
            end
            ole_pkg::OP_DEL_KEY:
            begin
                if (list_empty)
                begin
                    status_c = ole_pkg::STAT_EMPTY;
                end
                else if (!scan_found)
                begin
                    status_c = ole_pkg::STAT_MISSING;
                end
                else
                begin
                    edit_ctrl.remove = 1'b1;
                    edit_pos = scan_pos;
                    count_c = count_reg - 1'b1;
                end
            end
            ole_pkg::OP_DEL_BACK:
            begin
                if (list_empty)
                begin
                    status_c = ole_pkg::STAT_EMPTY;
                end
                else
                begin
                    count_c = count_reg - 1'b1;
                end
            end
            ole_pkg::OP_FIND:
            begin
                if (list_empty)
                begin
                    status_c = ole_pkg::STAT_EMPTY;
                end
                else if (!scan_found)
                begin
                    status_c = ole_pkg::STAT_MISSING;
                end
                else
                begin
                    position_c = 4'(scan_pos);
                end
            end
            ole_pkg::OP_SUM:
            begin
                total_c = scan_total;
            end
            default:
            begin
                status_c = ole_pkg::STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl        = '0;
        cell_ctrl.rotate = (state_reg == ole_pkg::S_SCAN);
        if (edit_fire)
        begin
            cell_ctrl.insert = edit_ctrl.insert;
            cell_ctrl.remove = edit_ctrl.remove;
        end
    end

    assign count_next     = edit_fire ? count_c : count_reg;
    assign out_valid_next = edit_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ole_pkg::S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_in;
            key_reg   <= key;
            value_reg <= value;
        end
        if (edit_fire)
        begin
            status_reg    <= status_c;
            position_reg  <= position_c;
            total_reg     <= total_c;
            occupancy_reg <= 5'(count_c);
        end
    end

    ole_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .step_en    (state_reg == ole_pkg::S_SCAN),
        .step       (step_reg),
        .count      (count_reg),
        .key        (key_reg),
        .head_value (cell_value[0]),
        .found      (scan_found),
        .match_pos  (scan_pos),
        .total      (scan_total)
    );

    // the chain closes into a ring: the last cell takes from the head
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ole_cell #(
            .INDEX (i),
            .POS_W (POS_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .edit_pos    (edit_pos),
            .left_value  (cell_value[(i == 0) ? 0 : i - 1]),
            .right_value (cell_value[(i == CAPACITY - 1) ? 0 : i + 1]),
            .load_value  (value_reg),
            .value       (cell_value[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign total     = total_reg;
    assign occupancy = occupancy_reg;

endmodule
